>>> hw/rtl/fnl_pkg.sv
// Shared types and constants of the FOR/NEXT loop stack.
package fnl_pkg;

  localparam int DATA_W    = 32;
  localparam int VAR_W     = 5;
  localparam int LINE_W    = 7;
  localparam int POS_W     = 7;
  localparam int DEPTH_W   = 4;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int NUM_VARS  = 26;
  // Frame index carried along the cell chain, wide enough for stacks of up to 64 cells.
  localparam int STACK_IDX_W = 6;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FOR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FOR   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [VAR_W-1:0]         var_index;
    logic                     has_var;
    logic signed [DATA_W-1:0] start_value;
    logic signed [DATA_W-1:0] end_value;
    logic signed [DATA_W-1:0] step_value;
    logic [LINE_W-1:0]        cur_line;
    logic [POS_W-1:0]         resume_pos;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     jump;
    logic [LINE_W-1:0]        jump_line;
    logic [POS_W-1:0]         jump_pos;
    logic signed [DATA_W-1:0] var_value;
    logic [DEPTH_W-1:0]       depth;
  } out_item_t;

  typedef struct packed {
    logic [VAR_W-1:0]         var_index;
    logic signed [DATA_W-1:0] end_value;
    logic signed [DATA_W-1:0] step_value;
    logic [LINE_W-1:0]        line;
    logic [POS_W-1:0]         pos;
  } frame_t;

  typedef struct packed {
    logic                   has_var;
    logic [VAR_W-1:0]       var_index;
  } query_t;

  typedef struct packed {
    logic                   found;
    logic [STACK_IDX_W-1:0] idx;
    frame_t                 frame;
  } link_t;

endpackage

>>> hw/rtl/for_next_loop_stack_core.sv
// Top level of the FOR/NEXT loop stack: command sequencer, variable file and cell chain.
//
// Usage: the interpreter sends one command item on in_item (in_valid/in_stall)
// and gets exactly one result item back on out_item (out_valid/out_stall).
// Commands are clear, let, read and for and next; each result carries status,
// jump target, the variable value after the command and the stack depth.
// Items are handled one at a time: in_stall is high from the cycle after
// acceptance until the result has moved into the output register.
// Command flow: clear, let, read and for go from S_EXEC straight to S_FIN,
// where the result moves into the output register. For next, the frame
// search ripples through the chain of STACK_DEPTH stack cells, one
// registered cell per cycle, while S_SCAN waits; then the step add (S_ADD)
// and the end compare (S_CHECK) follow before S_FIN. The output register
// holds a finished result while the receiver
// stalls, and a new command can be accepted meanwhile; the sequencer only
// waits if a second result is ready before the first was taken.
// Reset clears the variable file to zero, empties the stack and drops any
// pending result. Frame cells are not cleared; only frames below the top
// of stack are ever consulted.
module for_next_loop_stack_core #(
  parameter int STACK_DEPTH   = 8,
  parameter int PROGRAM_LINES = 128,
  parameter int LINE_LENGTH   = 80
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fnl_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fnl_pkg::out_item_t  out_item
);
  import fnl_pkg::*;

  localparam int TOP_W   = $clog2(STACK_DEPTH + 1);
  localparam int LINE_MAX = PROGRAM_LINES - 1;
  localparam int POS_MAX  = LINE_LENGTH - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_ADD,
    S_CHECK,
    S_FIN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [TOP_W-1:0]         cnt_r, cnt_nxt;
  in_item_t                 cmd_r, cmd_nxt;
  logic [TOP_W-1:0]         stack_top_r, stack_top_nxt;
  link_t                    match_r, match_nxt;
  logic signed [DATA_W-1:0] sum_r, sum_nxt;
  out_item_t                res_r, res_nxt;
  out_item_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Variable file: 26 registers, one write and one read per cycle.
  logic [DATA_W-1:0]        var_file_r [NUM_VARS];
  logic                     vf_clr;
  logic                     vf_we;
  logic [VAR_W-1:0]         vf_waddr;
  logic [DATA_W-1:0]        vf_wdata;
  logic [VAR_W-1:0]         rd_addr;
  logic [DATA_W-1:0]        rd_val;

  // Cell chain.
  link_t                    links [STACK_DEPTH+1];
  link_t                    chain_out;
  logic [STACK_DEPTH-1:0]   live;
  logic [STACK_DEPTH-1:0]   wr_en;
  logic                     push;
  frame_t                   push_frame;
  query_t                   query;

  logic [LINE_W-1:0]        line_sat;
  logic [POS_W-1:0]         pos_sat;
  logic                     var_ok;
  logic                     loop_done;
  logic [STACK_IDX_W:0]     match_next_top;

  assign chain_out = links[STACK_DEPTH];
  assign links[0]  = '0;
  assign query     = '{has_var: cmd_r.has_var, var_index: cmd_r.var_index};

  // Clamp the resume line and offset to the program's limits.
  assign line_sat = (int'(cmd_r.cur_line) > LINE_MAX) ? LINE_W'(LINE_MAX) : cmd_r.cur_line;
  assign pos_sat  = (int'(cmd_r.resume_pos) > POS_MAX) ? POS_W'(POS_MAX) : cmd_r.resume_pos;

  assign push_frame = '{var_index:  cmd_r.var_index,
                        end_value:  cmd_r.end_value,
                        step_value: cmd_r.step_value,
                        line:       line_sat,
                        pos:        pos_sat};

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      assign live[gi]  = (int'(stack_top_r) > gi);
      assign wr_en[gi] = push && (stack_top_r == TOP_W'(gi));
      fnl_cell #(
        .INDEX(gi)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .live    (live[gi]),
        .query   (query),
        .wr_en   (wr_en[gi]),
        .wr_frame(push_frame),
        .link_in (links[gi]),
        .link_out(links[gi+1])
      );
    end
  endgenerate

  // Read the matched frame's variable during the add, otherwise the named one.
  assign rd_addr = (state_r == S_ADD && chain_out.found) ?
                   chain_out.frame.var_index : cmd_r.var_index;
  assign rd_val  = (int'(rd_addr) < NUM_VARS) ? var_file_r[rd_addr] : '0;
  assign var_ok  = (int'(cmd_r.var_index) < NUM_VARS);

  // Loop ends once the variable steps past the bound; a zero step never ends.
  assign loop_done = (($signed(match_r.frame.step_value) > 0) &&
                      (sum_r > $signed(match_r.frame.end_value))) ||
                     (($signed(match_r.frame.step_value) < 0) &&
                      (sum_r < $signed(match_r.frame.end_value)));

  assign match_next_top = {1'b0, match_r.idx} + (STACK_IDX_W+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    stack_top_nxt = stack_top_r;
    match_nxt     = match_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    vf_clr        = 1'b0;
    vf_we         = 1'b0;
    vf_waddr      = cmd_r.var_index;
    vf_wdata      = cmd_r.start_value;
    push          = 1'b0;

    // Drop the result once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_item;
          cnt_nxt   = TOP_W'(1);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_FIN;
        case (cmd_r.cmd)
          CMD_CLEAR: begin
            vf_clr        = 1'b1;
            stack_top_nxt = '0;
          end
          CMD_LET: begin
            if (var_ok) begin
              vf_we             = 1'b1;
              res_nxt.var_value = cmd_r.start_value;
            end
          end
          CMD_READ: begin
            res_nxt.var_value = rd_val;
          end
          CMD_FOR: begin
            if (var_ok) begin
              vf_we             = 1'b1;
              res_nxt.var_value = cmd_r.start_value;
              if (int'(stack_top_r) >= STACK_DEPTH) begin
                res_nxt.status = ST_OVERFLOW;
              end else begin
                push          = 1'b1;
                stack_top_nxt = stack_top_r + TOP_W'(1);
              end
            end
          end
          CMD_NEXT: begin
            // Wait for the search to ripple through every cell.
            cnt_nxt   = cnt_r + TOP_W'(1);
            state_nxt = (int'(cnt_r) >= STACK_DEPTH) ? S_ADD : S_SCAN;
          end
          default: begin
            res_nxt.var_value = rd_val;
          end
        endcase
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + TOP_W'(1);
        if (int'(cnt_r) >= STACK_DEPTH) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (!chain_out.found) begin
          res_nxt.status    = ST_NO_FOR;
          res_nxt.var_value = cmd_r.has_var ? rd_val : '0;
          state_nxt         = S_FIN;
        end else begin
          match_nxt = chain_out;
          sum_nxt   = $signed(rd_val) + chain_out.frame.step_value;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        vf_we             = 1'b1;
        vf_waddr          = match_r.frame.var_index;
        vf_wdata          = sum_r;
        res_nxt.var_value = sum_r;
        if (loop_done) begin
          stack_top_nxt = TOP_W'(match_r.idx);
        end else begin
          // Pop everything above the matching frame and loop again.
          stack_top_nxt     = TOP_W'(match_next_top);
          res_nxt.jump      = 1'b1;
          res_nxt.jump_line = match_r.frame.line;
          res_nxt.jump_pos  = match_r.frame.pos;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_nxt.depth = DEPTH_W'(stack_top_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stack_top_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      stack_top_r <= stack_top_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    cmd_r   <= cmd_nxt;
    match_r <= match_nxt;
    sum_r   <= sum_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || vf_clr) begin
      for (int i = 0; i < NUM_VARS; i++) begin
        var_file_r[i] <= '0;
      end
    end else if (vf_we && (int'(vf_waddr) < NUM_VARS)) begin
      var_file_r[vf_waddr] <= vf_wdata;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> hw/rtl/fnl_cell.sv
// One stack cell: holds a FOR frame and forwards the highest match seen so far.
module fnl_cell #(
  parameter int INDEX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           live,
  input  fnl_pkg::query_t query,
  input  logic           wr_en,
  input  fnl_pkg::frame_t wr_frame,
  input  fnl_pkg::link_t link_in,
  output fnl_pkg::link_t link_out
);
  import fnl_pkg::*;

  frame_t frame_r;
  link_t  link_r;
  link_t  link_nxt;
  logic   hit;

  // A frame above the top of stack never matches.
  assign hit = live && (!query.has_var || (frame_r.var_index == query.var_index));

  always_comb begin
    link_nxt = link_in;
    if (hit) begin
      link_nxt.found = 1'b1;
      link_nxt.idx   = STACK_IDX_W'(INDEX);
      link_nxt.frame = frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_r <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else begin
      link_r <= link_nxt;
    end
  end

  assign link_out = link_r;

endmodule
